@@ src/blp_pkg.sv @@
// blp_pkg: types, codes and helper functions for the based integer literal parser.
// Used by blp_step and based_integer_literal_parser; no dependencies.
`timescale 1ns / 1ps

package blp_pkg;

	localparam int ACC_W = 64;
	localparam int LEN_W = 8;
	localparam int PROD_W = ACC_W + 4;

	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_UP_A   = 8'h41;
	localparam logic [7:0] CH_UP_Z   = 8'h5A;
	localparam logic [7:0] CH_LO_A   = 8'h61;
	localparam logic [7:0] CH_LO_Z   = 8'h7A;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [5:0] DIG_TEN   = 6'd10;
	localparam logic [5:0] DIG_NONE  = 6'd36;

	localparam logic [1:0] RADIX_BIN = 2'd0;
	localparam logic [1:0] RADIX_OCT = 2'd1;
	localparam logic [1:0] RADIX_DEC = 2'd2;
	localparam logic [1:0] RADIX_HEX = 2'd3;

	localparam logic [2:0] ST_BUSY    = 3'd0;
	localparam logic [2:0] ST_DONE    = 3'd1;
	localparam logic [2:0] ST_BADOPEN = 3'd2;
	localparam logic [2:0] ST_OVF     = 3'd3;
	localparam logic [2:0] ST_BADEND  = 3'd4;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_OPEN    = 3'd1,
		PH_FIRST   = 3'd2,
		PH_MORE    = 3'd3,
		PH_DONE    = 3'd4,
		PH_BADOPEN = 3'd5,
		PH_OVF     = 3'd6,
		PH_BADEND  = 3'd7
	} phase_t;

	typedef struct packed {
		logic [ACC_W-1:0] accum;
		phase_t           phase;
		logic [7:0]       quote_char;
		logic [LEN_W-1:0] char_count;
		logic [1:0]       radix_held;
		logic             quoted_held;
	} parse_state_t;

	function automatic logic [5:0] digit_of(input logic [7:0] c);
		logic [7:0] t;
		t = 8'd0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			t = c - CH_ZERO;
			return t[5:0];
		end
		if (c >= CH_UP_A && c <= CH_UP_Z) begin
			t = c - CH_UP_A;
			return t[5:0] + DIG_TEN;
		end
		if (c >= CH_LO_A && c <= CH_LO_Z) begin
			t = c - CH_LO_A;
			return t[5:0] + DIG_TEN;
		end
		return DIG_NONE;
	endfunction

	function automatic logic [5:0] radix_of(input logic [1:0] sel);
		logic [5:0] r;
		r = 6'd2;
		unique case (sel)
			RADIX_BIN: r = 6'd2;
			RADIX_OCT: r = 6'd8;
			RADIX_DEC: r = 6'd10;
			RADIX_HEX: r = 6'd16;
		endcase
		return r;
	endfunction

	function automatic logic [2:0] status_of(input phase_t ph);
		logic [2:0] s;
		s = ST_BUSY;
		unique case (ph)
			PH_DONE:    s = ST_DONE;
			PH_BADOPEN: s = ST_BADOPEN;
			PH_OVF:     s = ST_OVF;
			PH_BADEND:  s = ST_BADEND;
			default:    s = ST_BUSY;
		endcase
		return s;
	endfunction

endpackage

@@ src/blp_step.sv @@
// blp_step: next-state logic for one character of a based integer literal.
// Depends on blp_pkg.
`timescale 1ns / 1ps

module blp_step import blp_pkg::*; (
	input  parse_state_t     cur,
	input  logic [7:0]       ch,
	input  logic             start_req,
	input  logic [1:0]       radix_sel,
	input  logic             quoted,
	output parse_state_t     nxt,
	output logic [2:0]       status
);

	parse_state_t     base;
	logic [5:0]       dig;
	logic [5:0]       radix;
	logic             is_digit;
	logic [PROD_W-1:0] acc_ext;
	logic [PROD_W-1:0] prod;
	logic [PROD_W-1:0] sum;
	logic             ovf;
	logic [LEN_W-1:0] count_inc;

	always_comb begin
		base = cur;
		if (start_req) begin
			base.accum       = '0;
			base.quote_char  = '0;
			base.char_count  = '0;
			base.radix_held  = radix_sel;
			base.quoted_held = quoted;
			base.phase       = quoted ? PH_OPEN : PH_FIRST;
		end
	end

	assign dig      = digit_of(ch);
	assign radix    = radix_of(base.radix_held);
	assign is_digit = dig < radix;
	assign acc_ext  = {4'b0, base.accum};

	always_comb begin
		prod = acc_ext;
		unique case (base.radix_held)
			RADIX_BIN: prod = acc_ext << 1;
			RADIX_OCT: prod = acc_ext << 3;
			RADIX_DEC: prod = (acc_ext << 3) + (acc_ext << 1);
			RADIX_HEX: prod = acc_ext << 4;
		endcase
	end

	assign sum       = prod + {{(PROD_W-6){1'b0}}, dig};
	assign ovf       = |sum[PROD_W-1:ACC_W];
	assign count_inc = base.char_count + {{(LEN_W-1){1'b0}}, base.char_count != '1};

	always_comb begin
		nxt = base;
		unique case (base.phase)
			PH_OPEN: begin
				if (ch == CH_SQUOTE || ch == CH_DQUOTE) begin
					nxt.quote_char = ch;
					nxt.char_count = count_inc;
					nxt.phase      = PH_FIRST;
				end else begin
					nxt.phase = PH_BADOPEN;
				end
			end
			PH_FIRST, PH_MORE: begin
				if (is_digit) begin
					if (ovf) begin
						nxt.phase = PH_OVF;
					end else begin
						nxt.accum      = sum[ACC_W-1:0];
						nxt.char_count = count_inc;
						nxt.phase      = PH_MORE;
					end
				end else if (base.phase == PH_FIRST) begin
					nxt.phase = PH_BADOPEN;
				end else if (!base.quoted_held) begin
					nxt.phase = PH_DONE;
				end else if (ch == base.quote_char) begin
					nxt.char_count = count_inc;
					nxt.phase      = PH_DONE;
				end else begin
					nxt.phase = PH_BADEND;
				end
			end
			default: nxt = base;
		endcase
	end

	assign status = status_of(nxt.phase);

endmodule

@@ src/based_integer_literal_parser.sv @@
// based_integer_literal_parser: top level, input register, parse state and result register.
// Depends on blp_pkg and blp_step.
`timescale 1ns / 1ps

// Usage:
// Input channel (in_valid/in_ready) carries one character per item with start_req,
// radix_sel and quoted; start_req marks the first character of a new literal.
// Output channel (out_valid/out_ready) carries one result per input item: status,
// length and value after that character.
// An accepted item lands in the input register; on the next cycle, if the result
// register is free or being drained, the character is folded into the parse state
// and the result is registered.
// Throughput is one item per cycle while the receiver does not stall; the multiply-by-radix,
// digit add and overflow check on the 64-bit accumulator are combinational.
// When the receiver stalls, the result register holds, then the input register
// fills and in_ready drops; nothing is lost or repeated.
// Reset (arst_n low) empties both registers and returns the parse state to idle,
// where characters without start_req report busy, length 0, value 0.

module based_integer_literal_parser import blp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       ch,
	input  logic             start_req,
	input  logic [1:0]       radix_sel,
	input  logic             quoted,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [2:0]       status,
	output logic [LEN_W-1:0] length,
	output logic [ACC_W-1:0] value
);

	logic             valid_s1;
	logic [7:0]       ch_s1;
	logic             start_s1;
	logic [1:0]       radix_s1;
	logic             quoted_s1;
	parse_state_t     state_q;
	parse_state_t     state_nxt;
	logic [2:0]       status_nxt;
	logic             advance;

	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			ch_s1     <= ch;
			start_s1  <= start_req;
			radix_s1  <= radix_sel;
			quoted_s1 <= quoted;
		end
	end

	blp_step u_step (
		.cur       (state_q),
		.ch        (ch_s1),
		.start_req (start_s1),
		.radix_sel (radix_s1),
		.quoted    (quoted_s1),
		.nxt       (state_nxt),
		.status    (status_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.accum       <= '0;
			state_q.phase       <= PH_IDLE;
			state_q.quote_char  <= '0;
			state_q.char_count  <= '0;
			state_q.radix_held  <= '0;
			state_q.quoted_held <= 1'b0;
			out_valid           <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_nxt;
			end
			if (advance) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status <= status_nxt;
			length <= state_nxt.char_count;
			value  <= state_nxt.accum;
		end
	end

endmodule

@@ tb/tb_based_integer_literal_parser.sv @@
// tb_based_integer_literal_parser: self-checking bench for the based integer literal parser.
// Drives characters over valid/ready, predicts status, length and value per item, checks results.
// Depends on blp_pkg and based_integer_literal_parser.
`timescale 1ns / 1ps

module tb_based_integer_literal_parser;
	import blp_pkg::*;

	localparam int LIMIT      = 400000;
	localparam int CLOSE_GOOD = 0;
	localparam int CLOSE_BAD  = 1;
	localparam int CLOSE_NONE = 2;

	typedef struct {
		logic [7:0] ch;
		logic       start_req;
		logic [1:0] radix_sel;
		logic       quoted;
		bit         sync;
	} char_item_t;

	typedef struct {
		logic [2:0]       status;
		logic [LEN_W-1:0] length;
		logic [ACC_W-1:0] value;
	} parse_result_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [7:0]       ch = 8'd0;
	logic             start_req = 1'b0;
	logic [1:0]       radix_sel = 2'd0;
	logic             quoted = 1'b0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [2:0]       status;
	logic [LEN_W-1:0] length;
	logic [ACC_W-1:0] value;

	char_item_t    items_q[$];
	parse_result_t results_q[$];
	bit            hold_next = 1'b0;
	int            n_errors = 0;
	int            n_sent = 0;
	int            n_checked = 0;
	int            n_done = 0;
	int            n_failed = 0;
	int            n_ovf = 0;
	int            cycle_cnt = 0;
	int            burst_left = 10;
	int            gap_left = 0;

	logic [ACC_W-1:0] lit_acc = '0;
	phase_t           lit_phase = PH_IDLE;
	logic [7:0]       lit_quote = 8'd0;
	logic [LEN_W-1:0] lit_len = '0;
	logic [1:0]       lit_radix = RADIX_BIN;
	logic             lit_quoted = 1'b0;

	based_integer_literal_parser i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.ch(ch),
		.start_req(start_req),
		.radix_sel(radix_sel),
		.quoted(quoted),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.length(length),
		.value(value)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
	end

	function automatic int dig_val(input logic [7:0] c);
		if (c >= "0" && c <= "9")
			return int'(c) - int'(CH_ZERO);
		if (c >= "A" && c <= "Z")
			return int'(c) - int'(CH_UP_A) + 10;
		if (c >= "a" && c <= "z")
			return int'(c) - int'(CH_LO_A) + 10;
		return 36;
	endfunction

	function automatic int radix_val(input logic [1:0] sel);
		case (sel)
			RADIX_BIN: return 2;
			RADIX_OCT: return 8;
			RADIX_DEC: return 10;
			default:   return 16;
		endcase
	endfunction

	function automatic void bump_len();
		if (lit_len != 8'hFF)
			lit_len = lit_len + 8'd1;
	endfunction

	task automatic try_digit(input logic [7:0] c, output bit took);
		logic [67:0] prod;
		int          d;
		int          r;
		d = dig_val(c);
		r = radix_val(lit_radix);
		took = (d < r);
		if (took) begin
			prod = 68'(lit_acc) * 68'(r) + 68'(d);
			if (prod[67:64] != 4'd0) begin
				lit_phase = PH_OVF;
			end else begin
				lit_acc = prod[63:0];
				bump_len();
				lit_phase = PH_MORE;
			end
		end
	endtask

	task automatic fold_char(input char_item_t it, output parse_result_t r);
		bit took;
		if (it.start_req) begin
			lit_acc = '0;
			lit_quote = 8'd0;
			lit_len = '0;
			lit_radix = it.radix_sel;
			lit_quoted = it.quoted;
			lit_phase = it.quoted ? PH_OPEN : PH_FIRST;
		end
		case (lit_phase)
			PH_OPEN: begin
				if (it.ch == CH_SQUOTE || it.ch == CH_DQUOTE) begin
					lit_quote = it.ch;
					bump_len();
					lit_phase = PH_FIRST;
				end else begin
					lit_phase = PH_BADOPEN;
				end
			end
			PH_FIRST: begin
				try_digit(it.ch, took);
				if (!took)
					lit_phase = PH_BADOPEN;
			end
			PH_MORE: begin
				try_digit(it.ch, took);
				if (!took) begin
					if (!lit_quoted) begin
						lit_phase = PH_DONE;
					end else if (it.ch == lit_quote) begin
						bump_len();
						lit_phase = PH_DONE;
					end else begin
						lit_phase = PH_BADEND;
					end
				end
			end
			default: ;
		endcase
		case (lit_phase)
			PH_DONE:    r.status = ST_DONE;
			PH_BADOPEN: r.status = ST_BADOPEN;
			PH_OVF:     r.status = ST_OVF;
			PH_BADEND:  r.status = ST_BADEND;
			default:    r.status = ST_BUSY;
		endcase
		r.length = lit_len;
		r.value = lit_acc;
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("MISMATCH %s at result %0d: got %0h, expected %0h", what, n_checked, got, want);
		n_errors++;
	endtask

	// the radix and quoted fields only matter with start_req; randomize them otherwise
	task automatic add_item(input logic [7:0] c, input logic st, input logic [1:0] rs,
			input logic q);
		char_item_t it;
		it.ch = c;
		it.start_req = st;
		it.radix_sel = st ? rs : 2'($urandom_range(0, 3));
		it.quoted = st ? q : 1'($urandom_range(0, 1));
		it.sync = hold_next;
		hold_next = 1'b0;
		items_q.push_back(it);
	endtask

	function automatic logic [7:0] digit_char(input int d);
		if (d < 10)
			return CH_ZERO + 8'(d);
		return ($urandom_range(0, 1) ? CH_UP_A : CH_LO_A) + 8'(d - 10);
	endfunction

	function automatic logic [7:0] non_digit(input int r, input logic [7:0] avoid);
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (dig_val(b) < r || b == avoid);
		return b;
	endfunction

	task automatic push_literal(input logic [1:0] rs, input logic q, input int ndig,
			input int close_mode);
		logic [7:0] qc;
		bit         st;
		int         r;
		int         i;
		st = 1'b1;
		r = radix_val(rs);
		qc = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
		if (q) begin
			add_item(qc, st, rs, q);
			st = 1'b0;
		end
		for (i = 0; i < ndig; i++) begin
			add_item(digit_char($urandom_range(0, r - 1)), st, rs, q);
			st = 1'b0;
		end
		if (close_mode == CLOSE_GOOD)
			add_item(q ? qc : non_digit(r, 8'h00), st, rs, q);
		else if (close_mode == CLOSE_BAD)
			add_item(non_digit(r, qc), st, rs, q);
	endtask

	function automatic int max_digits(input logic [1:0] rs);
		case (rs)
			RADIX_BIN: return 64;
			RADIX_OCT: return 22;
			RADIX_DEC: return 20;
			default:   return 16;
		endcase
	endfunction

	initial begin
		int         i;
		int         k;
		int         n;
		logic [1:0] rs;
		logic       q;
		bit         sat_done;

		sat_done = 1'b0;
		add_item("5", 1'b0, RADIX_DEC, 1'b0);
		add_item(CH_DQUOTE, 1'b1, RADIX_HEX, 1'b1);
		for (i = 0; i < 16; i++)
			add_item(i[0] ? "f" : "F", 1'b0, RADIX_HEX, 1'b0);
		add_item("F", 1'b0, RADIX_HEX, 1'b0);
		add_item("1", 1'b0, RADIX_HEX, 1'b0);
		add_item(CH_SQUOTE, 1'b1, RADIX_OCT, 1'b1);
		add_item("7", 1'b0, RADIX_OCT, 1'b0);
		add_item(CH_DQUOTE, 1'b0, RADIX_OCT, 1'b0);
		add_item("1", 1'b1, RADIX_BIN, 1'b0);
		add_item("0", 1'b0, RADIX_BIN, 1'b0);
		add_item(8'hFF, 1'b0, RADIX_BIN, 1'b0);
		add_item("x", 1'b1, RADIX_HEX, 1'b1);
		add_item(CH_DQUOTE, 1'b1, RADIX_DEC, 1'b1);
		add_item(CH_DQUOTE, 1'b0, RADIX_DEC, 1'b0);
		add_item("9", 1'b1, RADIX_OCT, 1'b0);
		add_item("4", 1'b1, RADIX_DEC, 1'b0);
		add_item("2", 1'b0, RADIX_DEC, 1'b0);
		add_item("a", 1'b0, RADIX_DEC, 1'b0);
		add_item(8'h80, 1'b1, RADIX_HEX, 1'b0);

		hold_next = 1'b1;
		while (items_q.size() < 650) begin
			if (!sat_done && items_q.size() > 330) begin
				// length saturation: long run of leading zeros, then random bits
				sat_done = 1'b1;
				hold_next = 1'b1;
				add_item("0", 1'b1, RADIX_BIN, 1'b0);
				for (i = 0; i < 200; i++)
					add_item("0", 1'b0, RADIX_BIN, 1'b0);
				for (i = 0; i < 60; i++)
					add_item($urandom_range(0, 1) ? "1" : "0", 1'b0, RADIX_BIN, 1'b0);
				add_item(" ", 1'b0, RADIX_BIN, 1'b0);
			end
			rs = 2'($urandom_range(0, 3));
			q = 1'($urandom_range(0, 1));
			k = $urandom_range(0, 99);
			if (k < 70) begin
				if ($urandom_range(0, 9) == 0)
					n = max_digits(rs) + $urandom_range(0, 2) - 1;
				else
					n = $urandom_range(1, 6);
				push_literal(rs, q, n, ($urandom_range(0, 6) == 0) ? CLOSE_BAD : CLOSE_GOOD);
				if ($urandom_range(0, 2) == 0)
					for (i = $urandom_range(1, 3); i > 0; i--)
						add_item(8'($urandom_range(0, 255)), 1'b0, rs, q);
			end else if (k < 80) begin
				push_literal(rs, q, $urandom_range(0, 4), CLOSE_NONE);
			end else if (k < 90) begin
				add_item($urandom_range(0, 3) == 0 ? CH_SQUOTE : 8'($urandom_range(0, 255)),
					1'b1, rs, 1'b1);
				if ($urandom_range(0, 1))
					add_item($urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE, 1'b0, rs, q);
			end else begin
				for (i = $urandom_range(1, 5); i > 0; i--)
					add_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 9) == 0), rs, q);
			end
		end
	end

	always @(posedge clk) begin
		char_item_t    nxt;
		char_item_t    cur;
		parse_result_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				cur.ch = ch;
				cur.start_req = start_req;
				cur.radix_sel = radix_sel;
				cur.quoted = quoted;
				cur.sync = 1'b0;
				fold_char(cur, want);
				results_q.push_back(want);
				n_sent++;
			end
			if (!in_valid || in_ready) begin
				if (gap_left != 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (items_q.size() == 0 || (items_q[0].sync && results_q.size() != 0)) begin
					in_valid <= 1'b0;
				end else begin
					nxt = items_q.pop_front();
					ch <= nxt.ch;
					start_req <= nxt.start_req;
					radix_sel <= nxt.radix_sel;
					quoted <= nxt.quoted;
					in_valid <= 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = ($urandom_range(0, 7) == 0) ?
							$urandom_range(40, 120) : $urandom_range(1, 16);
						gap_left = $urandom_range(1, 6);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		parse_result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (results_q.size() == 0) begin
					report_mismatch("unexpected result", value, 64'd0);
				end else begin
					want = results_q.pop_front();
					if (status !== want.status)
						report_mismatch("status", 64'(status), 64'(want.status));
					if (length !== want.length)
						report_mismatch("length", 64'(length), 64'(want.length));
					if (value !== want.value)
						report_mismatch("value", value, want.value);
					if (want.status == ST_DONE)
						n_done++;
					else if (want.status == ST_OVF)
						n_ovf++;
					else if (want.status != ST_BUSY)
						n_failed++;
				end
				n_checked++;
			end
			case ((cycle_cnt / 256) % 4)
				0:       out_ready <= 1'b1;
				1:       out_ready <= ($urandom_range(0, 3) != 0);
				2:       out_ready <= (cycle_cnt % 7 < 4);
				default: out_ready <= 1'($urandom_range(0, 1));
			endcase
		end
	end

	initial begin
		while (cycle_cnt < LIMIT)
			@(posedge clk);
		$display("Timeout after %0d cycles, %0d results outstanding", cycle_cnt, results_q.size());
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		int n_total;
		@(posedge arst_n);
		n_total = items_q.size();
		while (n_checked < n_total)
			@(posedge clk);
		repeat (10) @(posedge clk);
		$display("Sent %0d characters and checked %0d results across all radixes and quote forms;",
			n_sent, n_checked);
		$display("results seen: %0d finished literal, %0d overflow, %0d other errors",
			n_done, n_ovf, n_failed);
		if (n_errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ files.f @@
src/blp_pkg.sv
src/blp_step.sv
src/based_integer_literal_parser.sv
tb/tb_based_integer_literal_parser.sv
